FILE: hw/rtl/seg_tri_pkg.sv
// Shared widths, types and helpers for the segment/triangle intersection pipeline.
package seg_tri_pkg;

  localparam int COORD_BITS = 16;
  localparam int NUM_AXES   = 3;
  localparam int PT_W       = 48;
  localparam int OUT_W      = 55;
  localparam int WORD_W     = 64;
  localparam int NUM_STAGES = 7;

  // exact widths of each arithmetic level
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD1_W = 2 * DIFF_W;
  localparam int CROSS_W = PROD1_W + 1;
  localparam int PROD2_W = DIFF_W + CROSS_W;
  localparam int DOT_W   = PROD2_W + 2;
  // compares run on values wrapped to at most one 64-bit word
  localparam int CMP_W   = (DOT_W > WORD_W) ? WORD_W : DOT_W;
  localparam int VW_W    = (CMP_W + 1 > WORD_W) ? WORD_W : CMP_W + 1;

  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD1_W-1:0] prod1_t;
  typedef logic signed [CROSS_W-1:0] cross_t;
  typedef logic signed [PROD2_W-1:0] prod2_t;
  typedef logic signed [DOT_W-1:0]   dot_t;
  typedef logic signed [CMP_W-1:0]   cmp_t;
  typedef logic signed [VW_W-1:0]    vw_t;
  typedef logic signed [OUT_W-1:0]   out_t;

  // signed coordinate idx of a packed point, sign-extended one bit
  function automatic diff_t coord(input logic [PT_W-1:0] pt, input int unsigned idx);
    logic [WORD_W-1:0]            ext;
    logic signed [COORD_BITS-1:0] c;
    ext = WORD_W'(pt);
    c   = $signed(ext[idx*COORD_BITS +: COORD_BITS]);
    return DIFF_W'(c);
  endfunction

  // low OUT_W bits of a dot product, sign-extended when narrower
  function automatic out_t to_out(input dot_t x);
    logic signed [DOT_W+OUT_W-1:0] ext;
    ext = (DOT_W+OUT_W)'(x);
    return ext[OUT_W-1:0];
  endfunction

  // dot product wrapped to the compare width
  function automatic cmp_t to_cmp(input dot_t x);
    logic signed [DOT_W+WORD_W-1:0] ext;
    ext = (DOT_W+WORD_W)'(x);
    return ext[CMP_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/segment_triangle_intersect.sv
// Pipelined segment versus front-facing triangle intersection test.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  query   | query_valid, query_stall, vertex_a/b/c,   | in
//          | seg_start, seg_end                        |
//  result  | result_valid, result_stall, hit, denom,   | out
//          | t_numer, v_numer, w_numer                 |
//
// One transaction per cycle while result_stall is low; seven register stages, the first
// loaded at the query accept edge and the seventh driving result_valid.
// rst (synchronous) clears only the stage valid bits; data regs are free.
// Each stage holds while the one after it is full and blocked, so empty
// stages still fill under a result stall and nothing is dropped or repeated.
module segment_triangle_intersect
  import seg_tri_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              query_valid,
  output logic              query_stall,
  input  logic [PT_W-1:0]   vertex_a,
  input  logic [PT_W-1:0]   vertex_b,
  input  logic [PT_W-1:0]   vertex_c,
  input  logic [PT_W-1:0]   seg_start,
  input  logic [PT_W-1:0]   seg_end,
  output logic              result_valid,
  input  logic              result_stall,
  output logic              hit,
  output out_t              denom,
  output out_t              t_numer,
  output out_t              v_numer,
  output out_t              w_numer
);

  // ---------------- stage control ----------------
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] rdy;
  logic [NUM_STAGES-1:0] ld;

  always_comb begin
    rdy[NUM_STAGES-1] = !vld[NUM_STAGES-1] || !result_stall;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
    ld[0] = rdy[0] && query_valid;
    for (int i = 1; i < NUM_STAGES; i++) begin
      ld[i] = rdy[i] && vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= query_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // ---------------- stage 1: edge and segment vectors ----------------
  diff_t ab1 [NUM_AXES];
  diff_t ac1 [NUM_AXES];
  diff_t qp1 [NUM_AXES];
  diff_t ap1 [NUM_AXES];

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        ab1[k] <= coord(vertex_b, k) - coord(vertex_a, k);
        ac1[k] <= coord(vertex_c, k) - coord(vertex_a, k);
        qp1[k] <= coord(seg_start, k) - coord(seg_end, k);
        ap1[k] <= coord(seg_start, k) - coord(vertex_a, k);
      end
    end
  end

  // ---------------- stage 2: cross product partial products ----------------
  // pp[2k] - pp[2k+1] is component k of the cross product
  prod1_t npp2 [2*NUM_AXES];
  prod1_t epp2 [2*NUM_AXES];
  diff_t  ab2 [NUM_AXES];
  diff_t  ac2 [NUM_AXES];
  diff_t  qp2 [NUM_AXES];
  diff_t  ap2 [NUM_AXES];

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      npp2[0] <= PROD1_W'(ab1[1]) * PROD1_W'(ac1[2]);
      npp2[1] <= PROD1_W'(ab1[2]) * PROD1_W'(ac1[1]);
      npp2[2] <= PROD1_W'(ab1[2]) * PROD1_W'(ac1[0]);
      npp2[3] <= PROD1_W'(ab1[0]) * PROD1_W'(ac1[2]);
      npp2[4] <= PROD1_W'(ab1[0]) * PROD1_W'(ac1[1]);
      npp2[5] <= PROD1_W'(ab1[1]) * PROD1_W'(ac1[0]);
      epp2[0] <= PROD1_W'(qp1[1]) * PROD1_W'(ap1[2]);
      epp2[1] <= PROD1_W'(qp1[2]) * PROD1_W'(ap1[1]);
      epp2[2] <= PROD1_W'(qp1[2]) * PROD1_W'(ap1[0]);
      epp2[3] <= PROD1_W'(qp1[0]) * PROD1_W'(ap1[2]);
      epp2[4] <= PROD1_W'(qp1[0]) * PROD1_W'(ap1[1]);
      epp2[5] <= PROD1_W'(qp1[1]) * PROD1_W'(ap1[0]);
      ab2 <= ab1;
      ac2 <= ac1;
      qp2 <= qp1;
      ap2 <= ap1;
    end
  end

  // ---------------- stage 3: normal n and e = qp x ap ----------------
  cross_t n3 [NUM_AXES];
  cross_t e3 [NUM_AXES];
  diff_t  ab3 [NUM_AXES];
  diff_t  ac3 [NUM_AXES];
  diff_t  qp3 [NUM_AXES];
  diff_t  ap3 [NUM_AXES];

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        n3[k] <= CROSS_W'(npp2[2*k]) - CROSS_W'(npp2[2*k+1]);
        e3[k] <= CROSS_W'(epp2[2*k]) - CROSS_W'(epp2[2*k+1]);
      end
      ab3 <= ab2;
      ac3 <= ac2;
      qp3 <= qp2;
      ap3 <= ap2;
    end
  end

  // ---------------- stage 4: dot product terms ----------------
  prod2_t dpp4 [NUM_AXES];
  prod2_t tpp4 [NUM_AXES];
  prod2_t vpp4 [NUM_AXES];
  prod2_t wpp4 [NUM_AXES];

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        dpp4[k] <= PROD2_W'(qp3[k]) * PROD2_W'(n3[k]);
        tpp4[k] <= PROD2_W'(ap3[k]) * PROD2_W'(n3[k]);
        vpp4[k] <= PROD2_W'(ac3[k]) * PROD2_W'(e3[k]);
        wpp4[k] <= PROD2_W'(ab3[k]) * PROD2_W'(e3[k]);
      end
    end
  end

  // ---------------- stage 5: dot product sums ----------------
  function automatic dot_t add3(input prod2_t x0, input prod2_t x1, input prod2_t x2);
    return DOT_W'(x0) + DOT_W'(x1) + DOT_W'(x2);
  endfunction

  dot_t d5, t5, v5, w5;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      d5 <= add3(dpp4[0], dpp4[1], dpp4[2]);
      t5 <= add3(tpp4[0], tpp4[1], tpp4[2]);
      v5 <= add3(vpp4[0], vpp4[1], vpp4[2]);
      w5 <= DOT_W'(0) - add3(wpp4[0], wpp4[1], wpp4[2]);
    end
  end

  // ---------------- stage 6: range checks, v+w ----------------
  cmp_t                d_c, t_c, v_c, w_c;
  logic signed [CMP_W:0] vw_sum;

  always_comb begin
    d_c    = to_cmp(d5);
    t_c    = to_cmp(t5);
    v_c    = to_cmp(v5);
    w_c    = to_cmp(w5);
    vw_sum = (CMP_W+1)'(v_c) + (CMP_W+1)'(w_c);
  end

  logic d_pos6, t_in6, v_in6, w_ge6;
  vw_t  vw6;
  cmp_t d6;
  out_t den6, tn6, vn6, wn6;

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      d_pos6 <= d_c > 0;
      t_in6  <= (t_c >= 0) && (t_c <= d_c);
      v_in6  <= (v_c >= 0) && (v_c <= d_c);
      w_ge6  <= w_c >= 0;
      vw6    <= vw_sum[VW_W-1:0];
      d6     <= d_c;
      den6   <= to_out(d5);
      tn6    <= to_out(t5);
      vn6    <= to_out(v5);
      wn6    <= to_out(w5);
    end
  end

  // ---------------- stage 7: result register ----------------
  always_ff @(posedge clk) begin
    if (ld[6]) begin
      hit     <= d_pos6 && t_in6 && v_in6 && w_ge6 && (vw6 <= d6);
      denom   <= den6;
      t_numer <= tn6;
      v_numer <= vn6;
      w_numer <= wn6;
    end
  end

  assign result_valid = vld[NUM_STAGES-1];
  assign query_stall  = !rdy[0];

endmodule

FILE: hw/rtl/seg_tri_check.sv
// Port-level assertions for segment_triangle_intersect, bound to the top level.
module seg_tri_check
  import seg_tri_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            query_stall,
  input logic            result_valid,
  input logic            result_stall,
  input logic            hit,
  input out_t            denom,
  input out_t            t_numer,
  input out_t            v_numer,
  input out_t            w_numer
);

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid set right after reset");

  // a blocked result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(hit) && $stable(denom)
      && $stable(t_numer) && $stable(v_numer) && $stable(w_numer))
    else $error("stalled result changed");

  // with the output stage empty every stage can move
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !query_stall)
    else $error("query stalled with empty output stage");

  // a hit needs front face and t in range
  a_hit_t: assert property (@(posedge clk) disable iff (rst)
    result_valid && hit |-> denom > 0 && t_numer >= 0 && t_numer <= denom)
    else $error("hit with denom or t_numer out of range");

  // a hit needs nonnegative barycentric numerators
  a_hit_vw: assert property (@(posedge clk) disable iff (rst)
    result_valid && hit |-> v_numer >= 0 && w_numer >= 0 && v_numer <= denom)
    else $error("hit with v_numer or w_numer out of range");

endmodule

bind segment_triangle_intersect seg_tri_check u_seg_tri_check (.*);

FILE: sim/segment_triangle_intersect_check.sv
// Checker: predicts each segment/triangle query and compares the result channel.
`timescale 1ns / 1ps

module segment_triangle_intersect_check
  import seg_tri_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            query_valid,
  input  logic            query_stall,
  input  logic [PT_W-1:0] vertex_a,
  input  logic [PT_W-1:0] vertex_b,
  input  logic [PT_W-1:0] vertex_c,
  input  logic [PT_W-1:0] seg_start,
  input  logic [PT_W-1:0] seg_end,
  input  logic            result_valid,
  input  logic            result_stall,
  input  logic            hit,
  input  out_t            denom,
  input  out_t            t_numer,
  input  out_t            v_numer,
  input  out_t            w_numer,
  output int              failures,
  output int              pending
);

  typedef logic signed [WORD_W-1:0] word_t;
  typedef struct { word_t x, y, z; } vec_t;
  typedef struct {
    logic hit;
    out_t denom;
    out_t t_numer;
    out_t v_numer;
    out_t w_numer;
  } crossing_t;

  crossing_t crossing_q[$];
  int        result_count = 0;

  function automatic vec_t unpack_point(input logic [PT_W-1:0] pt);
    logic signed [COORD_BITS-1:0] cx, cy, cz;
    vec_t v;
    cx  = pt[0*COORD_BITS +: COORD_BITS];
    cy  = pt[1*COORD_BITS +: COORD_BITS];
    cz  = pt[2*COORD_BITS +: COORD_BITS];
    v.x = word_t'(cx);
    v.y = word_t'(cy);
    v.z = word_t'(cz);
    return v;
  endfunction

  function automatic vec_t vec_sub(input vec_t l, input vec_t r);
    vec_t v;
    v.x = l.x - r.x;
    v.y = l.y - r.y;
    v.z = l.z - r.z;
    return v;
  endfunction

  function automatic vec_t vec_cross(input vec_t l, input vec_t r);
    vec_t v;
    v.x = l.y * r.z - l.z * r.y;
    v.y = l.z * r.x - l.x * r.z;
    v.z = l.x * r.y - l.y * r.x;
    return v;
  endfunction

  function automatic word_t vec_dot(input vec_t l, input vec_t r);
    return l.x * r.x + l.y * r.y + l.z * r.z;
  endfunction

  function automatic crossing_t predict_crossing(input logic [PT_W-1:0] pa, pb, pc, pp, pq);
    vec_t      a, b, c, p, q, ab, ac, qp, ap, n, e;
    word_t     d, t, v, w, vw;
    crossing_t r;
    a  = unpack_point(pa);
    b  = unpack_point(pb);
    c  = unpack_point(pc);
    p  = unpack_point(pp);
    q  = unpack_point(pq);
    ab = vec_sub(b, a);
    ac = vec_sub(c, a);
    qp = vec_sub(p, q);
    ap = vec_sub(p, a);
    n  = vec_cross(ab, ac);
    e  = vec_cross(qp, ap);
    d  = vec_dot(qp, n);
    t  = vec_dot(ap, n);
    v  = vec_dot(ac, e);
    w  = -vec_dot(ab, e);
    vw = v + w;
    r.hit     = (d > 0) && (t >= 0) && (t <= d) && (v >= 0) && (v <= d) &&
                (w >= 0) && (vw <= d);
    r.denom   = d[OUT_W-1:0];
    r.t_numer = t[OUT_W-1:0];
    r.v_numer = v[OUT_W-1:0];
    r.w_numer = w[OUT_W-1:0];
    return r;
  endfunction

  task automatic report(input string msg);
    $display("%0t ns: result %0d: %s", $time, result_count, msg);
    failures++;
  endtask

  task automatic check_field(input string name, input out_t want, input out_t got);
    if (got !== want)
      report($sformatf("%s expected %0d, got %0d", name, want, got));
  endtask

  crossing_t want;

  always @(posedge clk) begin
    if (rst) begin
      failures = 0;
      pending  = 0;
    end else begin
      if (query_valid && !query_stall)
        crossing_q.push_back(predict_crossing(vertex_a, vertex_b, vertex_c,
                                              seg_start, seg_end));
      if (result_valid && !result_stall) begin
        if (crossing_q.size() == 0) begin
          report("result transaction with no query outstanding");
        end else begin
          want = crossing_q.pop_front();
          check_field("hit", out_t'(want.hit), out_t'(hit));
          check_field("denom", want.denom, denom);
          check_field("t_numer", want.t_numer, t_numer);
          check_field("v_numer", want.v_numer, v_numer);
          check_field("w_numer", want.w_numer, w_numer);
        end
        result_count++;
      end
      pending = crossing_q.size();
    end
  end

endmodule

FILE: sim/segment_triangle_intersect_test.sv
// Testbench top: drives segment/triangle queries and gives the regression verdict.
`timescale 1ns / 1ps

module segment_triangle_intersect_test;
  import seg_tri_pkg::*;

  // generous cycle budget: worst case is every transaction eating a full sender
  // gap and a full result stall, with three drain pauses on top
  localparam int CYCLE_LIMIT   = 250000;
  localparam int RANDOM_ITEMS  = 1530;
  localparam int CALM_FROM     = 1380;  // no idling on either side past here
  localparam int PRESSURE_AT   = 700;   // mid-run drain of the pipeline
  localparam int TAIL_CYCLES   = 12;    // slack after the final drain

  typedef logic signed [COORD_BITS-1:0] coord_t;

  logic            clk          = 1'b0;
  logic            rst          = 1'b1;
  logic            query_valid  = 1'b0;
  logic            query_stall;
  logic [PT_W-1:0] vertex_a     = '0;
  logic [PT_W-1:0] vertex_b     = '0;
  logic [PT_W-1:0] vertex_c     = '0;
  logic [PT_W-1:0] seg_start    = '0;
  logic [PT_W-1:0] seg_end      = '0;
  logic            result_valid;
  logic            result_stall = 1'b0;
  logic            hit;
  out_t            denom, t_numer, v_numer, w_numer;

  int failures;
  int pending;
  int cycles    = 0;
  int idle_pct  = 0;   // sender idle chance per transaction, percent
  int stall_pct = 0;   // receiver stall burst chance per cycle, percent
  bit calm      = 1'b0;

  segment_triangle_intersect dut (
    .clk          (clk),
    .rst          (rst),
    .query_valid  (query_valid),
    .query_stall  (query_stall),
    .vertex_a     (vertex_a),
    .vertex_b     (vertex_b),
    .vertex_c     (vertex_c),
    .seg_start    (seg_start),
    .seg_end      (seg_end),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .hit          (hit),
    .denom        (denom),
    .t_numer      (t_numer),
    .v_numer      (v_numer),
    .w_numer      (w_numer)
  );

  // Watches both channels; owns the prediction and the mismatch count.
  segment_triangle_intersect_check checker_i (
    .clk          (clk),
    .rst          (rst),
    .query_valid  (query_valid),
    .query_stall  (query_stall),
    .vertex_a     (vertex_a),
    .vertex_b     (vertex_b),
    .vertex_c     (vertex_c),
    .seg_start    (seg_start),
    .seg_end      (seg_end),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .hit          (hit),
    .denom        (denom),
    .t_numer      (t_numer),
    .v_numer      (v_numer),
    .w_numer      (w_numer),
    .failures     (failures),
    .pending      (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("segment_triangle_intersect regression: fail");
      $finish;
    end
  end

  // Result side back-pressure: stall bursts at a rate the
  // stimulus changes from block to block; nothing once the run goes calm.
  initial begin
    int burst;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(99) < stall_pct) begin
        burst = $urandom_range(1, 7);
        result_stall <= 1'b1;
        repeat (burst - 1) @(negedge clk);
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Pack three Q8.8 coordinates, x in the low bits.
  function automatic logic [PT_W-1:0] pack3(input int x, input int y, input int z);
    return {coord_t'(z), coord_t'(y), coord_t'(x)};
  endfunction

  function automatic logic [PT_W-1:0] any_point();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[PT_W-1:0];
  endfunction

  function automatic int pick(input int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic int pick_span();
    case ($urandom_range(0, 3))
      0:       return 3;
      1:       return 60;
      2:       return 1000;
      default: return 8191;
    endcase
  endfunction

  // One query transaction: present at the falling edge, hold until accepted.
  task automatic send_query(input logic [PT_W-1:0] a, b, c, p, q);
    @(negedge clk);
    query_valid <= 1'b1;
    vertex_a    <= a;
    vertex_b    <= b;
    vertex_c    <= c;
    seg_start   <= p;
    seg_end     <= q;
    do @(posedge clk); while (query_stall);
  endtask

  task automatic idle_gap(input int n);
    @(negedge clk);
    query_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Stop sending and wait until every outstanding result has been taken.
  task automatic drain();
    @(negedge clk);
    query_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Well-formed case: a random triangle and a point X inside it (or on an
  // edge when a weight is zero), with a segment that crosses the plane at X,
  // ends on the plane, or stops short on one side. A random swap of the ends
  // flips front and back facing, so about half the crossings hit.
  task automatic send_segment_case(input int span);
    int a[3], b[3], c[3], x[3], dir[3], p[3], q[3], tmp[3];
    int wa, wb, wc, mode;
    wa = $urandom_range(0, 15);
    wb = $urandom_range(0, 15);
    wc = $urandom_range(0, 15);
    if (wa + wb + wc == 0) wa = 1;
    mode = $urandom_range(0, 7);
    for (int k = 0; k < 3; k++) begin
      a[k]   = pick(span);
      b[k]   = pick(span);
      c[k]   = pick(span);
      dir[k] = pick(span);
      x[k]   = (wa * a[k] + wb * b[k] + wc * c[k]) / (wa + wb + wc);
      case (mode)
        5: begin          // segment ends exactly on the plane
          p[k] = x[k] + dir[k];
          q[k] = x[k];
        end
        6: begin          // stops short on the far side
          p[k] = x[k] + 2 * dir[k];
          q[k] = x[k] + dir[k];
        end
        7: begin          // starts past the plane
          p[k] = x[k] - dir[k];
          q[k] = x[k] - 2 * dir[k];
        end
        default: begin
          p[k] = x[k] + dir[k];
          q[k] = x[k] - dir[k];
        end
      endcase
    end
    if ($urandom_range(0, 1)) begin
      tmp = p;
      p   = q;
      q   = tmp;
    end
    send_query(pack3(a[0], a[1], a[2]), pack3(b[0], b[1], b[2]),
               pack3(c[0], c[1], c[2]), pack3(p[0], p[1], p[2]),
               pack3(q[0], q[1], q[2]));
  endtask

  // Unstructured queries: full 48-bit noise or random points at one scale.
  task automatic send_noise(input int span);
    if ($urandom_range(0, 1))
      send_query(any_point(), any_point(), any_point(), any_point(), any_point());
    else
      send_query(pack3(pick(span), pick(span), pick(span)),
                 pack3(pick(span), pick(span), pick(span)),
                 pack3(pick(span), pick(span), pick(span)),
                 pack3(pick(span), pick(span), pick(span)),
                 pack3(pick(span), pick(span), pick(span)));
  endtask

  logic [PT_W-1:0] tri_a, tri_b, tri_c;

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: unit right triangle in z = 0, normal +z (256 is 1.0 in Q8.8).
    tri_a = pack3(0, 0, 0);
    tri_b = pack3(256, 0, 0);
    tri_c = pack3(0, 256, 0);
    send_query('0, '0, '0, '0, '0);                                   // all zero
    send_query('1, '1, '1, '1, '1);                                   // all -1
    send_query(tri_a, tri_b, tri_c, pack3(64, 64, 256), pack3(64, 64, -256));  // hit
    send_query(tri_a, tri_b, tri_c, pack3(64, 64, -256), pack3(64, 64, 256));  // back face
    send_query(tri_a, tri_b, tri_c, pack3(64, 64, 256), pack3(128, 64, 256));  // parallel
    send_query(tri_a, tri_b, tri_c, pack3(30, 40, 0), pack3(90, 10, 0));       // in plane
    send_query(tri_a, tri_b, pack3(512, 0, 0),
               pack3(64, 64, 256), pack3(64, 64, -256));              // degenerate
    send_query(tri_a, tri_b, tri_c, pack3(64, 64, 512), pack3(64, 64, 256));   // t > denom
    send_query(tri_a, tri_b, tri_c, pack3(64, 64, -256), pack3(64, 64, -512)); // t < 0
    send_query(tri_a, tri_b, tri_c, pack3(64, 64, 256), pack3(64, 64, 0));     // t == denom
    send_query(tri_a, tri_b, tri_c, pack3(64, 64, 0), pack3(64, 64, -256));    // t == 0
    send_query(tri_a, tri_b, tri_c, pack3(0, 0, 256), pack3(0, 0, -256));      // vertex A
    send_query(tri_a, tri_b, tri_c, pack3(128, 128, 256), pack3(128, 128, -256)); // v+w edge
    send_query(tri_a, tri_b, tri_c, pack3(100, 0, 256), pack3(100, 0, -256));  // w == 0 edge
    send_query(tri_a, tri_b, tri_c, pack3(300, 300, 256), pack3(300, 300, -256)); // outside
    send_query(tri_a, tri_b, tri_c, pack3(-10, 64, 256), pack3(-10, 64, -256));   // v < 0
    // coordinate extremes, both windings
    send_query(pack3(-32768, -32768, -32768), pack3(32767, -32768, -32768),
               pack3(-32768, 32767, -32768), pack3(0, 0, 32767), pack3(0, 0, -32768));
    send_query(pack3(-32768, -32768, -32768), pack3(-32768, 32767, -32768),
               pack3(32767, -32768, -32768), pack3(0, 0, 32767), pack3(0, 0, -32768));
    send_query(pack3(32767, 32767, 32767), pack3(-32768, 32767, -32768),
               pack3(32767, -32768, -32768), pack3(-32768, -32768, 32767),
               pack3(32767, 32767, -32768));
    send_query(any_point(), any_point(), any_point(), any_point(), any_point());

    // hold off the sender until the pipeline has fully emptied
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) begin
        idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 15 : 50);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 10 : 40);
      end
      if (i == CALM_FROM) calm = 1'b1;
      if (i == PRESSURE_AT) drain();
      if (!calm && $urandom_range(99) < idle_pct)
        idle_gap($urandom_range(1, 7));
      if ($urandom_range(99) < 70)
        send_segment_case(pick_span());
      else
        send_noise(pick_span());
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("segment_triangle_intersect regression: pass");
    else
      $display("segment_triangle_intersect regression: fail");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/seg_tri_pkg.sv
hw/rtl/segment_triangle_intersect.sv
hw/rtl/seg_tri_check.sv
sim/segment_triangle_intersect_check.sv
sim/segment_triangle_intersect_test.sv
